### sv/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold on every rising clock edge outside of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

### sv/bmhq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

  localparam int DEPTH        = 128;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Child indexes reach 2 * (DEPTH - 1) + 2.
  localparam int CHD_W = IDX_W + 2;
  localparam int ENT_W = KEY_BITS + PAYLOAD_BITS;

  // Operation codes of the kind field.
  localparam logic [2:0] KIND_INSERT  = 3'd0;
  localparam logic [2:0] KIND_EXTRACT = 3'd1;
  localparam logic [2:0] KIND_PEEK    = 3'd2;
  localparam logic [2:0] KIND_CLEAR   = 3'd3;
  localparam logic [2:0] KIND_LOAD    = 3'd4;
  localparam logic [2:0] KIND_HEAPIFY = 3'd5;

  typedef struct packed {
    logic [2:0]              kind;
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } bmhq_in_t;

  typedef struct packed {
    logic                    ok;
    logic [KEY_BITS-1:0]     out_key;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic [CNT_W-1:0]        count;
    logic                    empty_res;
  } bmhq_out_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } bmhq_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;          // take the input beat, clear the result
    logic pos_from_cnt; // hole position at the tail
    logic rd_up;        // read the parent of the hole
    logic up_move;      // parent moves down into the hole
    logic wr_cur;       // moving entry settles at the hole
    logic cnt_inc;
    logic cnt_clr;
    logic rd_ex;        // read root and last entry
    logic ex_take;      // root to result, last entry becomes the mover
    logic rd_dn;        // read both children of the hole
    logic dn_move;      // larger child moves up into the hole
    logic i_init;       // heap build starts at count / 2
    logic hp_rd;        // step to the next build node and read it
    logic hp_take;      // that node becomes the mover
    logic rd_root;
    logic pk_take;      // root to result
    logic set_ok;
    logic out_load;     // result into the output register
  } bmhq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic up_swap;
    logic leaf;
    logic dn_stay;
    logic i_zero;
  } bmhq_stat_t;

endpackage

`default_nettype wire

### sv/bmhq_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple RAM: one write port, two read ports with registered data.
module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### sv/bmhq_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bmhq_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bmhq_pkg::bmhq_in_t   in_data,
  input  wire bmhq_pkg::bmhq_cmd_t  cmd,
  output bmhq_pkg::bmhq_stat_t      stat,
  output bmhq_pkg::bmhq_out_t       out_data
);
  import bmhq_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  bmhq_entry_t      cur_r, cur_nxt;
  logic             res_ok_r, res_ok_nxt;
  bmhq_entry_t      res_r, res_nxt;
  bmhq_out_t        out_r, out_nxt;

  bmhq_entry_t      rd_a, rd_b, wdata;
  logic [ENT_W-1:0] rd_a_raw, rd_b_raw;
  logic [IDX_W-1:0] raddr_a, raddr_b, parent, pos_m1, i_m1;
  logic [CHD_W-1:0] left, right, cnt_ext;
  logic             we, go_left, go_right;
  logic [KEY_BITS-1:0] best_key;

  // Tree neighbors of the hole.
  assign pos_m1  = pos_r - IDX_W'(1);
  assign parent  = pos_m1 >> 1;
  assign left    = {1'b0, pos_r, 1'b1};
  assign right   = left + CHD_W'(1);
  assign cnt_ext = CHD_W'(count_r);
  assign i_m1    = i_r - IDX_W'(1);

  // Sift-down choice: step only to a strictly greater child.
  assign go_left  = rd_a.key > cur_r.key;
  assign best_key = go_left ? rd_a.key : cur_r.key;
  assign go_right = (right < cnt_ext) && (rd_b.key > best_key);

  assign stat.full     = (count_r == CNT_W'(DEPTH));
  assign stat.empty    = (count_r == '0);
  assign stat.pos_zero = (pos_r == '0);
  assign stat.up_swap  = rd_a.key < cur_r.key;
  assign stat.leaf     = !(left < cnt_ext);
  assign stat.dn_stay  = !go_left && !go_right;
  assign stat.i_zero   = (i_r == '0);

  // Memory addressing and write data.
  always_comb begin
    raddr_a = '0;
    if (cmd.rd_dn) begin
      raddr_a = left[IDX_W-1:0];
    end else if (cmd.rd_up) begin
      raddr_a = parent;
    end else if (cmd.hp_rd) begin
      raddr_a = i_m1;
    end
    raddr_b = cmd.rd_ex ? IDX_W'(count_r - CNT_W'(1)) : right[IDX_W-1:0];
    we      = cmd.wr_cur || cmd.up_move || cmd.dn_move;
    if (cmd.wr_cur) begin
      wdata = cur_r;
    end else if (cmd.dn_move && go_right) begin
      wdata = rd_b;
    end else begin
      wdata = rd_a;
    end
  end

  bmhq_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (pos_r),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a_raw),
    .rdata_b (rd_b_raw)
  );

  assign rd_a = rd_a_raw;
  assign rd_b = rd_b_raw;

  // Next-state logic of the working registers.
  always_comb begin
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    i_nxt      = i_r;
    cur_nxt    = cur_r;
    res_ok_nxt = res_ok_r;
    res_nxt    = res_r;
    out_nxt    = out_r;
    if (cmd.cap) begin
      cur_nxt.key     = in_data.key;
      cur_nxt.payload = in_data.payload;
      res_ok_nxt      = 1'b0;
      res_nxt         = '0;
    end
    if (cmd.pos_from_cnt) begin
      pos_nxt = IDX_W'(count_r);
    end
    if (cmd.up_move) begin
      pos_nxt = parent;
    end
    if (cmd.dn_move) begin
      pos_nxt = go_right ? right[IDX_W-1:0] : left[IDX_W-1:0];
    end
    if (cmd.ex_take) begin
      res_nxt    = rd_a;
      res_ok_nxt = 1'b1;
      cur_nxt    = rd_b;
      pos_nxt    = '0;
      count_nxt  = count_r - CNT_W'(1);
    end
    if (cmd.pk_take) begin
      res_nxt    = rd_a;
      res_ok_nxt = 1'b1;
    end
    if (cmd.i_init) begin
      i_nxt = IDX_W'(count_r >> 1);
    end
    if (cmd.hp_rd) begin
      i_nxt   = i_m1;
      pos_nxt = i_m1;
    end
    if (cmd.hp_take) begin
      cur_nxt = rd_a;
    end
    if (cmd.set_ok) begin
      res_ok_nxt = 1'b1;
    end
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (cmd.cnt_clr) begin
      count_nxt = '0;
    end
    if (cmd.out_load) begin
      out_nxt.ok          = res_ok_r;
      out_nxt.out_key     = res_r.key;
      out_nxt.out_payload = res_r.payload;
      out_nxt.count       = count_r;
      out_nxt.empty_res   = (count_r == '0);
    end
  end

  // Entry count is the only register here with a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    i_r      <= i_nxt;
    cur_r    <= cur_nxt;
    res_ok_r <= res_ok_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

### sv/bmhq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic [2:0]           in_kind,
  input  wire logic                 out_stall,
  input  wire bmhq_pkg::bmhq_stat_t stat,
  output logic                      in_stall,
  output logic                      out_valid,
  output bmhq_pkg::bmhq_cmd_t       cmd
);
  import bmhq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_UP_CHK, S_UP_CMP, S_EX_RD, S_EX_GET, S_DN_CHK, S_DN_CMP,
    S_HP_NEXT, S_HP_GET, S_PK_RD, S_PK_GET, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   hp_r, hp_nxt;
  state_t after_dn;

  // Sift-down returns to the heap build loop or finishes.
  assign after_dn = hp_r ? S_HP_NEXT : S_FIN;

  always_comb begin
    state_nxt     = state_r;
    hp_nxt        = hp_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          hp_nxt    = 1'b0;
          state_nxt = S_FIN;
          case (in_kind)
            KIND_INSERT: begin
              if (!stat.full) begin
                cmd.pos_from_cnt = 1'b1;
                state_nxt        = S_UP_CHK;
              end
            end
            KIND_LOAD: begin
              if (!stat.full) begin
                cmd.pos_from_cnt = 1'b1;
                state_nxt        = S_LOAD;
              end
            end
            KIND_EXTRACT: begin
              if (!stat.empty) begin
                state_nxt = S_EX_RD;
              end
            end
            KIND_PEEK: begin
              if (!stat.empty) begin
                state_nxt = S_PK_RD;
              end
            end
            KIND_CLEAR: begin
              cmd.cnt_clr = 1'b1;
              cmd.set_ok  = 1'b1;
            end
            KIND_HEAPIFY: begin
              cmd.i_init = 1'b1;
              cmd.set_ok = 1'b1;
              hp_nxt     = 1'b1;
              state_nxt  = S_HP_NEXT;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_LOAD: begin
        cmd.wr_cur  = 1'b1;
        cmd.cnt_inc = 1'b1;
        cmd.set_ok  = 1'b1;
        state_nxt   = S_FIN;
      end
      S_UP_CHK: begin
        if (stat.pos_zero) begin
          cmd.wr_cur  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.set_ok  = 1'b1;
          state_nxt   = S_FIN;
        end else begin
          cmd.rd_up = 1'b1;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat.up_swap) begin
          cmd.up_move = 1'b1;
          state_nxt   = S_UP_CHK;
        end else begin
          cmd.wr_cur  = 1'b1;
          cmd.cnt_inc = 1'b1;
          cmd.set_ok  = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_EX_RD: begin
        cmd.rd_ex = 1'b1;
        state_nxt = S_EX_GET;
      end
      S_EX_GET: begin
        cmd.ex_take = 1'b1;
        state_nxt   = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (stat.leaf) begin
          cmd.wr_cur = 1'b1;
          state_nxt  = after_dn;
        end else begin
          cmd.rd_dn = 1'b1;
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat.dn_stay) begin
          cmd.wr_cur = 1'b1;
          state_nxt  = after_dn;
        end else begin
          cmd.dn_move = 1'b1;
          state_nxt   = S_DN_CHK;
        end
      end
      S_HP_NEXT: begin
        if (stat.i_zero) begin
          state_nxt = S_FIN;
        end else begin
          cmd.hp_rd = 1'b1;
          state_nxt = S_HP_GET;
        end
      end
      S_HP_GET: begin
        cmd.hp_take = 1'b1;
        state_nxt   = S_DN_CHK;
      end
      S_PK_RD: begin
        cmd.rd_root = 1'b1;
        state_nxt   = S_PK_GET;
      end
      S_PK_GET: begin
        cmd.pk_take = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hp_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hp_r        <= hp_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### sv/binary_max_heap_queue.sv
// Binary max-heap priority queue of (key, payload) entries.
// Input channel: in_valid / in_stall carry one operation beat (kind, key,
// payload); a beat is taken when in_valid is high and in_stall is low.
// Kinds are insert, extract max, peek max, clear, load unordered and heapify.
// Output channel: out_valid / out_stall carry exactly one result beat per
// operation: ok flag, extracted or peeked entry, entry count and empty flag.
// One operation is worked on at a time; in_stall is high from acceptance
// until its result is in the output register.
// Clear, refused and unknown operations go straight to the result; load
// writes the entry at the tail and peek reads the root. Insert climbs from
// the tail and extract sinks the last entry from the root; heapify sinks
// each internal node in turn, from count / 2 - 1 down to the root.
// Every level of a climb or a sink is a registered read of the single
// entry RAM followed by a compare and write.
// A new operation may be accepted while the previous result is still held
// on a stalled output; the next result then waits in place.
// Reset empties the queue; the RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module binary_max_heap_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire bmhq_pkg::bmhq_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output bmhq_pkg::bmhq_out_t      out_data
);
  import bmhq_pkg::*;

  bmhq_cmd_t  cmd;
  bmhq_stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .out_stall (out_stall),
    .stat      (stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  bmhq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // At most one RAM write source per cycle.
  `ASSERT_ALWAYS(a_one_write, $onehot0({cmd.wr_cur, cmd.up_move, cmd.dn_move}), "write clash")
  // An accepted beat blocks the input until its result is out.
  `ASSERT_CLK(a_busy, (in_valid && !in_stall) |=> in_stall, "second beat accepted")
  // Reported count never exceeds capacity and agrees with the empty flag.
  `ASSERT_CLK(a_count, out_valid |-> ((out_data.count <= CNT_W'(DEPTH)) && (out_data.empty_res == (out_data.count == '0))), "bad count")

endmodule

`default_nettype wire

### tb/binary_max_heap_queue_tb.sv
`timescale 1ns / 1ps

module binary_max_heap_queue_tb;
  import bmhq_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  bmhq_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  bmhq_out_t out_data;

  binary_max_heap_queue u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Shadow copy of the queue that predicts every result.
  bmhq_entry_t shadow_heap [DEPTH];
  int          shadow_count;
  bmhq_out_t   pending_results [$];
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          results_seen;

  function automatic void shadow_swap(int a, int b);
    bmhq_entry_t t;
    t = shadow_heap[a];
    shadow_heap[a] = shadow_heap[b];
    shadow_heap[b] = t;
  endfunction

  function automatic void shadow_sift_down(int pos);
    int best;
    int l;
    int r;
    while (pos < shadow_count) begin
      best = pos;
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      if (l < shadow_count && shadow_heap[l].key > shadow_heap[best].key) best = l;
      if (r < shadow_count && shadow_heap[r].key > shadow_heap[best].key) best = r;
      if (best == pos) break;
      shadow_swap(pos, best);
      pos = best;
    end
  endfunction

  // Applies one operation to the shadow queue and returns the result beat.
  function automatic bmhq_out_t predict_heap_op(bmhq_in_t op);
    bmhq_out_t res;
    int pos;
    int up;
    res = '0;
    case (op.kind)
      KIND_INSERT, KIND_LOAD: begin
        if (shadow_count < DEPTH) begin
          shadow_heap[shadow_count] = {op.key, op.payload};
          if (op.kind == KIND_INSERT) begin
            pos = shadow_count;
            while (pos > 0) begin
              up = (pos - 1) / 2;
              if (!(shadow_heap[up].key < shadow_heap[pos].key)) break;
              shadow_swap(pos, up);
              pos = up;
            end
          end
          shadow_count++;
          res.ok = 1'b1;
        end
      end
      KIND_EXTRACT: begin
        if (shadow_count > 0) begin
          res.ok = 1'b1;
          res.out_key = shadow_heap[0].key;
          res.out_payload = shadow_heap[0].payload;
          shadow_heap[0] = shadow_heap[shadow_count - 1];
          shadow_count--;
          shadow_sift_down(0);
        end
      end
      KIND_PEEK: begin
        if (shadow_count > 0) begin
          res.ok = 1'b1;
          res.out_key = shadow_heap[0].key;
          res.out_payload = shadow_heap[0].payload;
        end
      end
      KIND_CLEAR: begin
        shadow_count = 0;
        res.ok = 1'b1;
      end
      KIND_HEAPIFY: begin
        for (int i = shadow_count / 2 - 1; i >= 0; i--) shadow_sift_down(i);
        res.ok = 1'b1;
      end
      default: ;
    endcase
    res.count = shadow_count[CNT_W-1:0];
    res.empty_res = (shadow_count == 0);
    return res;
  endfunction

  // Sends one beat with a random idle gap and records its prediction.
  // Valid stays high after acceptance unless an idle gap follows.
  task automatic send_op(logic [2:0] kind, logic [KEY_BITS-1:0] key,
                         logic [PAYLOAD_BITS-1:0] payload);
    bmhq_in_t op;
    op.kind = kind;
    op.key = key;
    op.payload = payload;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_heap_op(op));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compares each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    bmhq_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result beat %p", out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.ok !== want.ok || out_data.out_key !== want.out_key ||
            out_data.out_payload !== want.out_payload ||
            out_data.count !== want.count || out_data.empty_res !== want.empty_res) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  task automatic test_empty_cases();
    send_op(KIND_EXTRACT, '1, '1);
    send_op(KIND_PEEK, '0, '0);
    send_op(KIND_HEAPIFY, '0, '0);
    send_op(3'd6, '1, '1);
    send_op(3'd7, 16'h1234, 32'h5678_9abc);
    send_op(KIND_INSERT, '1, '1);
    send_op(KIND_HEAPIFY, '0, '0);
    send_op(KIND_INSERT, '0, '0);
    send_op(KIND_INSERT, '1, 32'h0000_0001);
    send_op(KIND_PEEK, '0, '0);
    send_op(KIND_EXTRACT, '0, '0);
    send_op(KIND_EXTRACT, '0, '0);
    send_op(KIND_EXTRACT, '0, '0);
    send_op(KIND_EXTRACT, '0, '0);
  endtask

  // Fills the queue to capacity, offers two more entries, then drains it in order.
  task automatic test_full_queue();
    send_op(KIND_CLEAR, '0, '0);
    for (int i = 0; i < DEPTH; i++)
      send_op(KIND_INSERT, KEY_BITS'($urandom_range(40)), $urandom);
    send_op(KIND_INSERT, '1, '1);
    send_op(KIND_LOAD, '1, '1);
    send_op(KIND_PEEK, '0, '0);
    for (int i = 0; i < DEPTH + 1; i++) send_op(KIND_EXTRACT, '0, '0);
  endtask

  // Clear, loads and heapify build a heap from a list; half of it is then extracted.
  task automatic test_build_heap(int n);
    send_op(KIND_CLEAR, '0, '0);
    for (int i = 0; i < n; i++)
      send_op(KIND_LOAD, KEY_BITS'($urandom_range(65535)), $urandom);
    send_op(KIND_HEAPIFY, '0, '0);
    for (int i = 0; i < n / 2; i++) send_op(KIND_EXTRACT, '0, '0);
  endtask

  task automatic test_random_mix(int n);
    logic [2:0] kind;
    int pick;
    logic [KEY_BITS-1:0] key;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) kind = KIND_INSERT;
      else if (pick < 75) kind = KIND_EXTRACT;
      else if (pick < 83) kind = KIND_PEEK;
      else if (pick < 92) kind = KIND_LOAD;
      else if (pick < 96) kind = KIND_HEAPIFY;
      else if (pick < 98) kind = KIND_CLEAR;
      else kind = 3'($urandom_range(7, 6));
      key = ($urandom_range(1) != 0) ? 16'($urandom_range(15)) : 16'($urandom);
      send_op(kind, key, $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    shadow_count = 0;
    mismatch_count = 0;
    results_seen = 0;
    send_idle_pct = 38;
    recv_idle_pct = 64;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_cases();
    test_full_queue();
    test_build_heap(37);
    test_random_mix(300);
    wait_drained();

    send_idle_pct = 64;
    recv_idle_pct = 38;
    test_build_heap(DEPTH);
    test_random_mix(300);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_build_heap(20);
    test_random_mix(300);
    wait_drained();
    repeat (50) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
